@@ rtl/kpsd_pkg.sv @@
// ----------------------------------------------------------------------------
// kpsd_pkg
// Shared types and constants for the keypad scan, debounce and release unit.
// ----------------------------------------------------------------------------
package kpsd_pkg;

    // Matrix geometry defaults
    localparam int unsigned ROWS_DEFAULT = 4;
    localparam int unsigned COLS_DEFAULT = 4;

    // Snapshot width and the number of keys that have a character
    localparam int unsigned KEY_BITS  = 16;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned ELAPSED_W = 11;
    localparam int unsigned TICK_W    = 8;
    localparam int unsigned DEBOUNCE_W = 10;

    // Configuration port
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_TICK_STEP_MS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_MS  = 2'd1;

    localparam logic [TICK_W-1:0]     TICK_STEP_RESET = 8'd10;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET  = 10'd40;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

    // Character of each key position, row-major
    localparam logic [CHAR_W-1:0] KEY_CHARS [KEY_BITS] = '{
        8'h31, 8'h32, 8'h33, 8'h41,   // 1 2 3 A
        8'h34, 8'h35, 8'h36, 8'h42,   // 4 5 6 B
        8'h37, 8'h38, 8'h39, 8'h43,   // 7 8 9 C
        8'h2A, 8'h30, 8'h23, 8'h44    // * 0 # D
    };

    // Timing settings handed to the phase machine
    typedef struct packed {
        logic [TICK_W-1:0]     tick_step_ms;
        logic [DEBOUNCE_W-1:0] debounce_ms;
    } kpsd_cfg_t;

endpackage

@@ rtl/kpsd_key_find.sv @@
// ----------------------------------------------------------------------------
// kpsd_key_find
// Picks the first closed key in row-major order and maps it to its character.
// Returns zero when no key is closed.
// ----------------------------------------------------------------------------
module kpsd_key_find #(
    parameter int unsigned ROWS = kpsd_pkg::ROWS_DEFAULT,
    parameter int unsigned COLS = kpsd_pkg::COLS_DEFAULT
) (
    input  logic [kpsd_pkg::KEY_BITS-1:0] key_closed,
    output logic [kpsd_pkg::CHAR_W-1:0]   key_char
);

    // Positions at or beyond the snapshot width are never seen as closed
    localparam int unsigned KEY_N = (ROWS * COLS < kpsd_pkg::KEY_BITS) ?
                                    ROWS * COLS : kpsd_pkg::KEY_BITS;

    // Priority select: walk down so the lowest position wins
    always_comb
    begin
        key_char = '0;
        for (int p = KEY_N - 1; p >= 0; p--)
        begin
            if (key_closed[p])
            begin
                key_char = kpsd_pkg::KEY_CHARS[p];
            end
        end
    end

endmodule

@@ rtl/kpsd_phase_fsm.sv @@
// ----------------------------------------------------------------------------
// kpsd_phase_fsm
// Scanning, debounce and hold phases with the saturating debounce timer.
// Produces the released character for the tick being retired.
// ----------------------------------------------------------------------------
module kpsd_phase_fsm (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic [kpsd_pkg::CHAR_W-1:0] key_char,
    input  kpsd_pkg::kpsd_cfg_t         cfg,
    output logic [kpsd_pkg::CHAR_W-1:0] released_key
);

    typedef enum logic [1:0] {
        SCANNING = 2'd0,
        DEBOUNCE = 2'd1,
        HOLD     = 2'd2
    } phase_t;

    phase_t                              phase_reg, phase_next;
    logic [kpsd_pkg::CHAR_W-1:0]         held_reg, held_next;
    logic [kpsd_pkg::ELAPSED_W-1:0]      elapsed_reg, elapsed_next;
    logic [kpsd_pkg::ELAPSED_W:0]        elapsed_sum;
    logic                                timer_done;

    // Saturating timer add and threshold compare on the old value
    assign elapsed_sum = {1'b0, elapsed_reg} +
                         {{(kpsd_pkg::ELAPSED_W + 1 - kpsd_pkg::TICK_W){1'b0}},
                          cfg.tick_step_ms};
    assign timer_done  = elapsed_reg >=
                         {{(kpsd_pkg::ELAPSED_W - kpsd_pkg::DEBOUNCE_W){1'b0}},
                          cfg.debounce_ms};

    // Next phase, held key, timer and released character
    always_comb
    begin
        phase_next   = phase_reg;
        held_next    = held_reg;
        elapsed_next = elapsed_reg;
        released_key = '0;
        unique case (phase_reg)
            SCANNING:
            begin
                if (key_char != '0)
                begin
                    held_next    = key_char;
                    elapsed_next = '0;
                    phase_next   = DEBOUNCE;
                end
            end
            DEBOUNCE:
            begin
                if (timer_done)
                begin
                    phase_next = (key_char == held_reg) ? HOLD : SCANNING;
                end
                if (elapsed_sum[kpsd_pkg::ELAPSED_W])
                begin
                    elapsed_next = kpsd_pkg::ELAPSED_MAX;
                end
                else
                begin
                    elapsed_next = elapsed_sum[kpsd_pkg::ELAPSED_W-1:0];
                end
            end
            HOLD:
            begin
                if (key_char != held_reg)
                begin
                    if (key_char == '0)
                    begin
                        released_key = held_reg;
                    end
                    phase_next = SCANNING;
                end
            end
            default:
            begin
                phase_next = SCANNING;
            end
        endcase
    end

    // Hold state; advance only when a tick retires
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= SCANNING;
            held_reg    <= '0;
            elapsed_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            held_reg    <= held_next;
            elapsed_reg <= elapsed_next;
        end
    end

`ifndef ASSERT_OFF
    a_release_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (released_key != '0) |-> (phase_reg == HOLD && key_char == '0))
        else $error("release outside hold phase");

    a_scan_to_debounce: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && phase_reg == SCANNING && key_char != '0) |=>
        (phase_reg == DEBOUNCE && held_reg == $past(key_char) && elapsed_reg == '0))
        else $error("key capture into debounce failed");

    a_timer_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && phase_reg == DEBOUNCE) |=> (elapsed_reg >= $past(elapsed_reg)))
        else $error("debounce timer went backward");
`endif

endmodule

@@ rtl/keypad_scan_debounce_release_unit.sv @@
// ----------------------------------------------------------------------------
// keypad_scan_debounce_release_unit
// Matrix keypad tick processor: finds the first closed key, debounces it and
// reports its character on the tick it is released.
//
//   Channel | Direction | Signals                          | Content
//   --------+-----------+----------------------------------+------------------
//   s       | in        | s_tvalid s_tready s_tdata[15:0]  | key_closed
//   m       | out       | m_tvalid m_tready m_tdata[7:0]   | released_key
//   cfg     | in        | cfg_valid cfg_ready cfg_index    | tick_step_ms (0),
//           |           | cfg_data[9:0]                    | debounce_ms (1)
//
// One tick per cycle sustained while m_tready is high; each tick passes from
// the input register through the phase logic into the result register. Reset
// clears the phase machine, both stage valid flags and loads the default
// timing settings. A stalled output holds the result register and the input
// register still takes one tick before s_tready drops.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module keypad_scan_debounce_release_unit #(
    parameter int unsigned ROWS = kpsd_pkg::ROWS_DEFAULT,
    parameter int unsigned COLS = kpsd_pkg::COLS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Tick input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [kpsd_pkg::KEY_BITS-1:0]    s_tdata,   // [15:0] key_closed
    // Release output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [kpsd_pkg::CHAR_W-1:0]      m_tdata,   // [7:0] released_key
    // Configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [kpsd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [kpsd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic                            in_valid_reg;
    logic [kpsd_pkg::KEY_BITS-1:0]   key_closed_reg;
    logic                            out_valid_reg;
    logic [kpsd_pkg::CHAR_W-1:0]     released_reg;
    logic                            advance;
    logic [kpsd_pkg::CHAR_W-1:0]     key_char;
    logic [kpsd_pkg::CHAR_W-1:0]     released_next;
    kpsd_pkg::kpsd_cfg_t             cfg_reg;

    // Retire the held tick when the result register is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = released_reg;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_step_ms <= kpsd_pkg::TICK_STEP_RESET;
            cfg_reg.debounce_ms  <= kpsd_pkg::DEBOUNCE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                kpsd_pkg::REG_TICK_STEP_MS:
                    cfg_reg.tick_step_ms <= cfg_data[kpsd_pkg::TICK_W-1:0];
                kpsd_pkg::REG_DEBOUNCE_MS:
                    cfg_reg.debounce_ms  <= cfg_data[kpsd_pkg::DEBOUNCE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            key_closed_reg <= s_tdata;
        end
        if (advance)
        begin
            released_reg <= released_next;
        end
    end

    kpsd_key_find #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_key_find (
        .key_closed (key_closed_reg),
        .key_char   (key_char)
    );

    kpsd_phase_fsm u_phase_fsm (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .key_char     (key_char),
        .cfg          (cfg_reg),
        .released_key (released_next)
    );

`ifndef ASSERT_OFF
    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("retired tick did not reach the result register");

    a_full_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while both stages are stalled");
`endif

endmodule
